// ===== hdl/bmp24_stream_decoder_defines.svh =====
// ----------------------------------------------------------------------------
// BMP stream decoder assertion macros
// Shared property shorthands for the decoder checks, clocked on clock and
// switched off while reset is high.
// ----------------------------------------------------------------------------
`ifndef BMP24_STREAM_DECODER_DEFINES_SVH
`define BMP24_STREAM_DECODER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BMP24_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BMP24_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/bmp24_pkg.sv =====
// ----------------------------------------------------------------------------
// BMP stream decoder package
// Request and response payload types, result kinds and header layout.
// ----------------------------------------------------------------------------
`default_nettype none

package bmp24_pkg;

   typedef enum logic [2:0] {
      KIND_PIXEL         = 3'd0,
      KIND_HEADER_OK     = 3'd1,
      KIND_BAD_SIGNATURE = 3'd2,
      KIND_NOT_24BPP     = 3'd3,
      KIND_COMPRESSED    = 3'd4,
      KIND_TOO_LARGE     = 3'd5,
      KIND_BAD_OFFSET    = 3'd6
   } kind_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       start_of_file;
   } req_type;

   typedef struct packed {
      kind_type    kind;
      logic [11:0] column;
      logic [11:0] dest_row;
      logic [25:0] dest_address;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  alpha;
      logic [12:0] image_width;
      logic [12:0] image_height;
      logic        last_pixel;
   } rsp_type;

   // Byte positions of the header fields, all little-endian.
   localparam logic [5:0]  HDR_SIG_POS    = 6'd0;
   localparam logic [5:0]  HDR_OFFSET_POS = 6'd10;
   localparam logic [5:0]  HDR_WIDTH_POS  = 6'd18;
   localparam logic [5:0]  HDR_HEIGHT_POS = 6'd22;
   localparam logic [5:0]  HDR_BPP_POS    = 6'd28;
   localparam logic [5:0]  HDR_COMP_POS   = 6'd30;
   localparam logic [5:0]  HDR_LAST_POS   = 6'd53;
   localparam logic [31:0] HDR_BYTES      = 32'd54;

   localparam logic [15:0] BMP_SIGNATURE  = 16'h4D42;
   localparam logic [15:0] BMP_BPP        = 16'd24;
   localparam logic [7:0]  ALPHA_OPAQUE   = 8'hFF;

endpackage

`default_nettype wire

// ===== hdl/bmp24_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// BMP 24-bit stream decoder
// Parses the header of an uncompressed 24 bpp BMP file arriving one byte at a
// time, then turns each BGR triple into an RGBA pixel with its address in a
// top-down destination buffer.
// ----------------------------------------------------------------------------
//   Channel   Direction   Payload               Handshake
//   req_      in          bmp24_pkg::req_type   req_valid / req_stall
//   rsp_      out         bmp24_pkg::rsp_type   rsp_valid / rsp_stall
//
// One byte is accepted per cycle when req_stall is low; rsp_ is registered.
// The header check, the pixel address multiply-add and the state update all
// complete in the cycle the byte is accepted.
// A two-entry output buffer absorbs rsp_stall; req_stall rises only when both
// entries are full.
// Reset (synchronous) returns the block to idle, waiting for a start of file.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bmp24_stream_decoder_defines.svh"

module bmp24_stream_decoder #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  wire                logic clock,
   input  wire                logic reset,
   input  wire                logic req_valid,
   output                     logic req_stall,
   input  wire bmp24_pkg::req_type req_data,
   output                     logic rsp_valid,
   input  wire                logic rsp_stall,
   output      bmp24_pkg::rsp_type rsp_data
);

   localparam int WIDTH_BITS  = $clog2(MAX_WIDTH + 1);
   localparam int HEIGHT_BITS = $clog2(MAX_HEIGHT + 1);
   localparam int PROD_BITS   = (WIDTH_BITS + HEIGHT_BITS + 1 > 24) ?
                                (WIDTH_BITS + HEIGHT_BITS + 1) : 24;
   localparam int COL_EXT     = (WIDTH_BITS > 12) ? WIDTH_BITS : 12;
   localparam int ROW_EXT     = (HEIGHT_BITS > 12) ? HEIGHT_BITS : 12;

   typedef enum logic [5:0] {
      PH_IDLE   = 6'b000001,
      PH_HEADER = 6'b000010,
      PH_SKIP   = 6'b000100,
      PH_PIXELS = 6'b001000,
      PH_PAD    = 6'b010000,
      PH_DONE   = 6'b100000
   } phase_type;

   phase_type               phase_ff, phase_in, phase_eff;
   logic [31:0]             pos_ff, pos_in, pos_eff;
   logic [15:0]             sig_ff, sig_in;
   logic [31:0]             offset_ff, offset_in;
   logic [31:0]             width_ff, width_in;
   logic [31:0]             height_ff, height_in;
   logic [15:0]             bpp_ff, bpp_in;
   logic [31:0]             comp_ff, comp_in;
   logic [WIDTH_BITS-1:0]   col_ff, col_in;
   logic [HEIGHT_BITS-1:0]  row_ff, row_in;
   logic [1:0]              tri_ff, tri_in;
   logic [1:0]              pad_ff, pad_in;
   logic [7:0]              blue_ff, blue_in;
   logic [7:0]              green_ff, green_in;

   logic                    out_valid_ff, out_valid_in;
   bmp24_pkg::rsp_type      out_ff, out_in;
   logic                    skid_valid_ff, skid_valid_in;
   bmp24_pkg::rsp_type      skid_ff, skid_in;

   logic                    accept;
   logic                    start;
   logic                    res_valid;
   bmp24_pkg::rsp_type      res;
   logic [5:0]              hdr_pos;
   logic [7:0]              b;

   logic [WIDTH_BITS-1:0]   width_w;
   logic [HEIGHT_BITS-1:0]  height_h;
   logic [HEIGHT_BITS-1:0]  drow;
   logic [WIDTH_BITS-1:0]   col_next;
   logic [HEIGHT_BITS-1:0]  row_next;
   logic                    col_end;
   logic                    last;
   logic [PROD_BITS-1:0]    prod;
   logic [COL_EXT-1:0]      col_ext;
   logic [ROW_EXT-1:0]      drow_ext;
   logic [32:0]             skip_next;
   bmp24_pkg::kind_type     hdr_kind;

   assign accept    = req_valid && !req_stall;
   assign req_stall = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   assign start     = accept && req_data.start_of_file;
   assign phase_eff = start ? PH_HEADER : phase_ff;
   assign pos_eff   = start ? 32'd0 : pos_ff;
   assign hdr_pos   = pos_eff[5:0];
   assign b         = req_data.data_byte;

   // Pixel geometry; the header has already bounded width and height.
   assign width_w   = width_ff[WIDTH_BITS-1:0];
   assign height_h  = height_ff[HEIGHT_BITS-1:0];
   assign drow      = height_h - HEIGHT_BITS'(1) - row_ff;
   assign col_next  = col_ff + WIDTH_BITS'(1);
   assign row_next  = row_ff + HEIGHT_BITS'(1);
   assign col_end   = (col_next == width_w);
   assign last      = col_end && (row_next == height_h);
   assign prod      = PROD_BITS'(drow) * PROD_BITS'(width_w) + PROD_BITS'(col_ff);
   assign col_ext   = COL_EXT'(col_ff);
   assign drow_ext  = ROW_EXT'(drow);
   assign skip_next = {1'b0, pos_ff} + 33'd1;

   always_comb begin
      if (sig_ff != bmp24_pkg::BMP_SIGNATURE) begin
         hdr_kind = bmp24_pkg::KIND_BAD_SIGNATURE;
      end else if (bpp_ff != bmp24_pkg::BMP_BPP) begin
         hdr_kind = bmp24_pkg::KIND_NOT_24BPP;
      end else if (comp_ff != 32'd0) begin
         hdr_kind = bmp24_pkg::KIND_COMPRESSED;
      end else if (width_ff > 32'(MAX_WIDTH) || height_ff > 32'(MAX_HEIGHT)) begin
         hdr_kind = bmp24_pkg::KIND_TOO_LARGE;
      end else if (offset_ff < bmp24_pkg::HDR_BYTES) begin
         hdr_kind = bmp24_pkg::KIND_BAD_OFFSET;
      end else begin
         hdr_kind = bmp24_pkg::KIND_HEADER_OK;
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      sig_in    = sig_ff;
      offset_in = offset_ff;
      width_in  = width_ff;
      height_in = height_ff;
      bpp_in    = bpp_ff;
      comp_in   = comp_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      tri_in    = tri_ff;
      pad_in    = pad_ff;
      blue_in   = blue_ff;
      green_in  = green_ff;

      res_valid          = 1'b0;
      res                = '0;
      res.kind           = bmp24_pkg::KIND_HEADER_OK;
      res.alpha          = bmp24_pkg::ALPHA_OPAQUE;

      if (accept) begin
         case (phase_eff)
            PH_HEADER: begin
               // Every field byte is overwritten before the header is judged,
               // so no clearing is needed at the start of a file.
               if (hdr_pos < bmp24_pkg::HDR_SIG_POS + 6'd2) begin
                  sig_in[{hdr_pos[0], 3'b000} +: 8] = b;
               end
               if (hdr_pos >= bmp24_pkg::HDR_OFFSET_POS &&
                   hdr_pos <  bmp24_pkg::HDR_OFFSET_POS + 6'd4) begin
                  offset_in[{2'(hdr_pos - bmp24_pkg::HDR_OFFSET_POS), 3'b000} +: 8] = b;
               end
               if (hdr_pos >= bmp24_pkg::HDR_WIDTH_POS &&
                   hdr_pos <  bmp24_pkg::HDR_WIDTH_POS + 6'd4) begin
                  width_in[{2'(hdr_pos - bmp24_pkg::HDR_WIDTH_POS), 3'b000} +: 8] = b;
               end
               if (hdr_pos >= bmp24_pkg::HDR_HEIGHT_POS &&
                   hdr_pos <  bmp24_pkg::HDR_HEIGHT_POS + 6'd4) begin
                  height_in[{2'(hdr_pos - bmp24_pkg::HDR_HEIGHT_POS), 3'b000} +: 8] = b;
               end
               if (hdr_pos >= bmp24_pkg::HDR_BPP_POS &&
                   hdr_pos <  bmp24_pkg::HDR_BPP_POS + 6'd2) begin
                  bpp_in[{1'(hdr_pos - bmp24_pkg::HDR_BPP_POS), 3'b000} +: 8] = b;
               end
               if (hdr_pos >= bmp24_pkg::HDR_COMP_POS &&
                   hdr_pos <  bmp24_pkg::HDR_COMP_POS + 6'd4) begin
                  comp_in[{2'(hdr_pos - bmp24_pkg::HDR_COMP_POS), 3'b000} +: 8] = b;
               end
               pos_in = pos_eff + 32'd1;
               phase_in = PH_HEADER;
               if (hdr_pos == bmp24_pkg::HDR_LAST_POS) begin
                  res_valid = 1'b1;
                  res.kind  = hdr_kind;
                  if (hdr_kind != bmp24_pkg::KIND_HEADER_OK) begin
                     phase_in = PH_DONE;
                  end else begin
                     res.image_width  = width_ff[12:0];
                     res.image_height = height_ff[12:0];
                     col_in = '0;
                     row_in = '0;
                     tri_in = 2'd0;
                     pad_in = 2'd0;
                     pos_in = bmp24_pkg::HDR_BYTES;
                     if (width_ff == 32'd0 || height_ff == 32'd0) begin
                        phase_in = PH_DONE;
                     end else if (offset_ff == bmp24_pkg::HDR_BYTES) begin
                        phase_in = PH_PIXELS;
                     end else begin
                        phase_in = PH_SKIP;
                     end
                  end
               end
            end
            PH_SKIP: begin
               if (skip_next >= {1'b0, offset_ff}) begin
                  phase_in = PH_PIXELS;
               end
               pos_in = skip_next[31:0];
            end
            PH_PIXELS: begin
               case (tri_ff)
                  2'd0: begin
                     blue_in = b;
                     tri_in  = 2'd1;
                  end
                  2'd1: begin
                     green_in = b;
                     tri_in   = 2'd2;
                  end
                  default: begin
                     tri_in           = 2'd0;
                     res_valid        = 1'b1;
                     res.kind         = bmp24_pkg::KIND_PIXEL;
                     res.column       = col_ext[11:0];
                     res.dest_row     = drow_ext[11:0];
                     res.dest_address = {prod[23:0], 2'b00};
                     res.red          = b;
                     res.green        = green_ff;
                     res.blue         = blue_ff;
                     res.last_pixel   = last;
                     col_in           = col_next;
                     if (col_end) begin
                        col_in = '0;
                        if (last) begin
                           phase_in = PH_DONE;
                        end else begin
                           row_in = row_next;
                           // Rows are padded by width mod 4 bytes.
                           pad_in = width_ff[1:0];
                           if (width_ff[1:0] != 2'd0) begin
                              phase_in = PH_PAD;
                           end
                        end
                     end
                  end
               endcase
            end
            PH_PAD: begin
               pad_in = pad_ff - 2'd1;
               if (pad_ff == 2'd1) begin
                  phase_in = PH_PIXELS;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Output register with a skid entry behind it.
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
      if (skid_valid_ff && !out_valid_in) begin
         out_in        = skid_ff;
         out_valid_in  = 1'b1;
         skid_valid_in = 1'b0;
      end
      if (res_valid) begin
         if (!out_valid_in) begin
            out_in       = res;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = res;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         pos_ff        <= 32'd0;
         col_ff        <= '0;
         row_ff        <= '0;
         tri_ff        <= 2'd0;
         pad_ff        <= 2'd0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         pos_ff        <= pos_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         tri_ff        <= tri_in;
         pad_ff        <= pad_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sig_ff    <= sig_in;
      offset_ff <= offset_in;
      width_ff  <= width_in;
      height_ff <= height_in;
      bpp_ff    <= bpp_in;
      comp_ff   <= comp_in;
      blue_ff   <= blue_in;
      green_ff  <= green_in;
      out_ff    <= out_in;
      skid_ff   <= skid_in;
   end

   `BMP24_ASSERT_NOW(a_skid_behind_out, skid_valid_ff, out_valid_ff, "skid entry held without an output entry")
   `BMP24_ASSERT_NEXT(a_done_sticky, phase_ff == PH_DONE && !start, phase_ff == PH_DONE, "decoder left done without a start of file")
   `BMP24_ASSERT_NOW(a_pixel_needs_image, res_valid && res.kind == bmp24_pkg::KIND_PIXEL, width_ff != 32'd0 && height_ff != 32'd0, "pixel produced for an empty image")
   `BMP24_ASSERT_NEXT(a_result_kept, out_valid_ff && rsp_stall, out_valid_ff, "stalled response dropped")

endmodule

`default_nettype wire
